// ===== rtl/pcom_pkg.sv =====
// Types and constants for the periodic per-type center-of-mass block.
// No dependencies.
`timescale 1ns / 1ps
package pcom_pkg;
  localparam int unsigned NUM_REGS = 3;
  localparam logic [1:0] REG_TYPES = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_ITER  = 2'd2;
  localparam int unsigned DIV_W = 64;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_CLR   = 9'b000000010,
    S_RD    = 9'b000000100,
    S_WRAP  = 9'b000001000,
    S_ACC   = 9'b000010000,
    S_MEAN  = 9'b000100000,
    S_UPD   = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  // shared rounding divider control
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
  } div_req_t;
endpackage

// ===== rtl/periodic_center_of_mass_per_type.sv =====
// Periodic per-type center of mass: a top level with atom memories, sequencer
// and one shared divider/multiplier path. Depends on pcom_pkg and pcom_div.
//
// Usage: atoms arrive on the in_ channel (valid/ready). Each accepted request
// stores one atom, one per cycle, while the block sits in its load state;
// atoms beyond MAX_ATOMS are accepted but not stored. The request with
// in_last_atom set starts the refinement passes; in_ready is low until all
// per-type results have been taken on the out_ channel. A pass visits every
// stored atom and runs one rounding division per axis on the shared
// bit-serial divider for atoms of a used type on axes with nonzero cell
// length, then one division per type with atoms and axis for the means. A
// frame takes up to max_iterations passes.
// Results: types_in_use requests, type 0 first, last_center on the final one.
// A stalled receiver holds the current result; nothing is dropped.
// cfg_ writes take effect at once and belong to idle time only.
// Reset (synchronous, rst_n low) clears centers, counts and the sticky error
// flag; the atom memories are not cleared since every read hits an atom of
// the current frame.
`timescale 1ns / 1ps
module periodic_center_of_mass_per_type #(
  parameter int MAX_ATOMS = 4096,
  parameter int MAX_TYPES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [2:0]         in_species,
  input  logic [30:0]        in_cell_len_x,
  input  logic [30:0]        in_cell_len_y,
  input  logic [30:0]        in_cell_len_z,
  input  logic               in_restart,
  input  logic               in_last_atom,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_type_index,
  output logic signed [31:0] out_center_x,
  output logic signed [31:0] out_center_y,
  output logic signed [31:0] out_center_z,
  output logic               out_no_convergence,
  output logic               out_error_seen,
  output logic               out_last_center
);
  import pcom_pkg::*;

  localparam int AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW  = $clog2(MAX_ATOMS + 1);
  localparam int TW  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int NTY = (MAX_TYPES < 8) ? MAX_TYPES : 8;
  localparam int SW  = 48;

  // configuration
  logic [3:0]  types_r;
  logic [15:0] tol_r;
  logic [7:0]  iter_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      types_r <= 4'd1; tol_r <= 16'd1; iter_r <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TYPES: types_r <= cfg_data[3:0];
        REG_TOL:   tol_r   <= cfg_data;
        REG_ITER:  iter_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [3:0] nt;
  logic [7:0] limit;
  always_comb begin
    nt = types_r;
    if (nt == 4'd0) nt = 4'd1;
    if (nt > 4'(NTY)) nt = 4'(NTY);
    limit = (iter_r == 8'd0) ? 8'd1 : iter_r;
  end

  // atom memories
  logic [31:0] mem_x [MAX_ATOMS];
  logic [31:0] mem_y [MAX_ATOMS];
  logic [31:0] mem_z [MAX_ATOMS];
  logic [2:0]  mem_t [MAX_ATOMS];
  logic [31:0] rd_x, rd_y, rd_z;
  logic [2:0]  rd_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [30:0] len_r [3];
  logic signed [31:0] cen_r [NTY][3];
  logic signed [SW-1:0] sum_r [NTY][3];
  logic [CW-1:0] tcnt_r [NTY];
  logic [1:0] ax_r, ax_nxt;
  logic [TW-1:0] ty_r, ty_nxt;
  logic [7:0] pass_r, pass_nxt;
  logic [37:0] shift_r, shift_nxt;
  logic err_r, fail_r;
  logic signed [33:0] n_r;
  logic signed [63:0] prod_r;
  logic mult_r;

  div_req_t dreq;
  logic dbusy, ddone;
  logic signed [DIV_W-1:0] dquo;
  pcom_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .done(ddone),
                  .quo(dquo));

  logic accept;
  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept && cnt_r < CW'(MAX_ATOMS)) begin
      mem_x[cnt_r[AW-1:0]] <= in_pos_x;
      mem_y[cnt_r[AW-1:0]] <= in_pos_y;
      mem_z[cnt_r[AW-1:0]] <= in_pos_z;
      mem_t[cnt_r[AW-1:0]] <= in_species;
    end
    rd_x <= mem_x[idx_r[AW-1:0]];
    rd_y <= mem_y[idx_r[AW-1:0]];
    rd_z <= mem_z[idx_r[AW-1:0]];
    rd_t <= mem_t[idx_r[AW-1:0]];
  end

  // current atom coordinate and type selections
  logic [31:0] cur_coord;
  logic [30:0] cur_len;
  logic [TW-1:0] rt;
  logic rt_used;
  always_comb begin
    unique case (ax_r)
      2'd0: cur_coord = rd_x;
      2'd1: cur_coord = rd_y;
      default: cur_coord = rd_z;
    endcase
    cur_len = (ax_r == 2'd0) ? len_r[0] : (ax_r == 2'd1) ? len_r[1] : len_r[2];
    rt = TW'(rd_t);
    rt_used = ({1'b0, rd_t} < nt) && (32'(rd_t) < MAX_TYPES);
  end

  logic signed [33:0] n_calc;
  assign n_calc = $signed({{2{cur_coord[31]}}, cur_coord})
                - 34'(cen_r[rt][ax_r]);

  logic signed [SW-1:0] cur_sum;
  assign cur_sum = sum_r[ty_r][ax_r];
  logic signed [33:0] new_cen;
  logic signed [SW-1:0] mabs;
  assign mabs = dquo[63] ? -SW'(dquo) : SW'(dquo);

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r; ax_nxt = ax_r;
    ty_nxt = ty_r; pass_nxt = pass_r; shift_nxt = shift_r;
    dreq = '0;
    new_cen = 34'(cen_r[ty_r][ax_r]) + 34'(dquo);
    unique case (state_r)
      S_LOAD: if (accept) begin
        if (cnt_r < CW'(MAX_ATOMS)) cnt_nxt = cnt_r + 1'b1;
        if (in_last_atom) begin
          state_nxt = S_CLR; pass_nxt = '0;
        end
      end
      S_CLR: begin
        idx_nxt = '0; shift_nxt = '0; state_nxt = S_RD;
      end
      S_RD: begin
        // wait here for the registered memory read data
        ax_nxt = 2'd0;
        if (idx_r == cnt_r) begin
          ty_nxt = '0; state_nxt = S_MEAN;
        end else state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (!rt_used) begin
          idx_nxt = idx_r + 1'b1; state_nxt = S_RD;
        end else if (cur_len == '0) state_nxt = S_ACC;
        else if (!dbusy && !ddone) begin
          dreq.start = 1'b1; dreq.neg = n_calc[33];
          dreq.num = n_calc[33] ? 64'(-n_calc) : 64'(n_calc);
          dreq.den = 64'(cur_len);
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if ((cur_len == '0) || mult_r) begin
          if (ax_r == 2'd2) begin
            idx_nxt = idx_r + 1'b1; state_nxt = S_RD;
          end else begin
            ax_nxt = ax_r + 1'b1; state_nxt = S_WRAP;
          end
        end
      end
      S_MEAN: begin
        if (tcnt_r[ty_r] == '0) state_nxt = S_UPD;
        else if (!dbusy && !ddone) begin
          dreq.start = 1'b1; dreq.neg = cur_sum[SW-1];
          dreq.num = cur_sum[SW-1] ? 64'(-cur_sum) : 64'(cur_sum);
          dreq.den = 64'(tcnt_r[ty_r]);
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (tcnt_r[ty_r] == '0 || ddone) begin
          if (tcnt_r[ty_r] != '0) shift_nxt = shift_r + 38'(mabs);
          if (ax_r == 2'd2) begin
            ax_nxt = 2'd0;
            if (4'(ty_r) + 4'd1 == nt) begin
              pass_nxt = pass_r + 1'b1; state_nxt = S_CHECK;
            end else begin
              ty_nxt = ty_r + 1'b1; state_nxt = S_MEAN;
            end
          end else begin
            ax_nxt = ax_r + 1'b1; state_nxt = S_MEAN;
          end
        end
      end
      S_CHECK: begin
        if (shift_r <= 38'(tol_r) || pass_r >= limit) begin
          ty_nxt = '0; state_nxt = S_EMIT;
        end else state_nxt = S_CLR;
      end
      S_EMIT: if (out_ready) begin
        if (4'(ty_r) + 4'd1 == nt) begin
          cnt_nxt = '0; state_nxt = S_LOAD;
        end else ty_nxt = ty_r + 1'b1;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; idx_r <= '0; ax_r <= '0; ty_r <= '0;
      pass_r <= '0; shift_r <= '0; err_r <= 1'b0; fail_r <= 1'b0; mult_r <= 1'b0;
      for (int t = 0; t < NTY; t++) begin
        tcnt_r[t] <= '0;
        for (int a = 0; a < 3; a++) begin
          cen_r[t][a] <= '0; sum_r[t][a] <= '0;
        end
      end
      for (int a = 0; a < 3; a++) len_r[a] <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt; ax_r <= ax_nxt;
      ty_r <= ty_nxt; pass_r <= pass_nxt; shift_r <= shift_nxt;
      mult_r <= (state_r == S_ACC) && ddone;
      if (accept) begin
        if (in_restart)
          for (int t = 0; t < NTY; t++)
            for (int a = 0; a < 3; a++) cen_r[t][a] <= '0;
        if (cnt_r == '0) begin
          len_r[0] <= in_cell_len_x; len_r[1] <= in_cell_len_y;
          len_r[2] <= in_cell_len_z;
        end
      end
      if (state_r == S_CLR)
        for (int t = 0; t < NTY; t++) begin
          tcnt_r[t] <= '0;
          for (int a = 0; a < 3; a++) sum_r[t][a] <= '0;
        end
      if (state_r == S_WRAP) n_r <= n_calc;
      // one multiply k*L after the divider finishes, then accumulate
      if (state_r == S_ACC && ddone)
        prod_r <= $signed(dquo[33:0]) * $signed({1'b0, cur_len});
      if (state_r == S_ACC && ((cur_len == '0) || mult_r)) begin
        sum_r[rt][ax_r] <= sum_r[rt][ax_r]
          + ((cur_len == '0) ? SW'(n_r) : SW'(66'(n_r) - 66'(prod_r)));
        if (ax_r == 2'd0) tcnt_r[rt] <= tcnt_r[rt] + 1'b1;
      end
      if (state_r == S_UPD && ddone && tcnt_r[ty_r] != '0)
        cen_r[ty_r][ax_r] <= (new_cen > 34'sd2147483647) ? 32'sh7fffffff :
                             (new_cen < -34'sd2147483648) ? 32'sh80000000 :
                             new_cen[31:0];
      if (state_r == S_CHECK && state_nxt == S_EMIT) begin
        fail_r <= (shift_r > 38'(tol_r));
        if (shift_r > 38'(tol_r)) err_r <= 1'b1;
      end
    end
  end

  assign out_valid          = (state_r == S_EMIT);
  assign out_type_index     = 3'(ty_r);
  assign out_center_x       = cen_r[ty_r][0];
  assign out_center_y       = cen_r[ty_r][1];
  assign out_center_z       = cen_r[ty_r][2];
  assign out_no_convergence = fail_r;
  assign out_error_seen     = err_r;
  assign out_last_center    = (4'(ty_r) + 4'd1 == nt);

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output active together");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(err_r) |-> err_r) else $error("sticky error cleared");
  a_fail_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_convergence |-> out_error_seen)
    else $error("failure without sticky flag");
  a_pass_lim: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> pass_r <= limit) else $error("pass limit exceeded");
endmodule

// ===== rtl/pcom_div.sv =====
// Bit-serial rounding divider: |n|/d rounded to nearest, ties away from zero.
// Depends on pcom_pkg. One quotient bit per cycle.
`timescale 1ns / 1ps
module pcom_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcom_pkg::div_req_t         req,
  output logic                       busy,
  output logic                       done,
  output logic signed [pcom_pkg::DIV_W-1:0] quo
);
  import pcom_pkg::*;
  localparam int CW = $clog2(DIV_W + 1);
  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] q_r, q_nxt, n_r, n_nxt, d_r, d_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [DIV_W:0]   trial;

  always_comb begin
    rem_nxt = rem_r; q_nxt = q_r; n_nxt = n_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; neg_nxt = neg_r;
    trial = {rem_r[DIV_W-1:0], n_r[DIV_W-1]};
    if (req.start) begin
      // (2a + d) / (2d): numerator fits in 64 bits for |n| < 2^61
      n_nxt = (req.num << 1) + req.den;
      d_nxt = req.den << 1;
      rem_nxt = '0; q_nxt = '0; cnt_nxt = CW'(DIV_W);
      busy_nxt = 1'b1; neg_nxt = req.neg;
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; q_r <= q_nxt; n_r <= n_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
